FILE: rtl/assert_macros.svh
// Assertion macros for the checker file of the motion detector.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`endif

FILE: rtl/fdmd_pkg.sv
// Shared constants, types and helper functions of the motion detector.
// Used by fdmd_cfg, fdmd_core and the top level; no dependencies.
package fdmd_pkg;

  localparam int unsigned MAX_DIM   = 2048;
  localparam int unsigned COORD_W   = $clog2(MAX_DIM);
  localparam int unsigned DIM_W     = COORD_W + 1;
  localparam int unsigned REG_DIM_W = 12;
  localparam int unsigned CNT_W     = 23;
  localparam int unsigned ACC_W     = 33;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned PERM_W    = 10;

  localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
  localparam logic [ACC_W-1:0] PERMILLE_DEN = ACC_W'(1000);

  // The threshold is 255 * pct / 100, with the division done as a multiply by
  // 5243 / 2^19, which is exact for every product below 2^15.
  localparam logic [12:0] PCT_RECIP      = 13'd5243;
  localparam int unsigned PCT_RECIP_SHIFT = 19;

  typedef enum logic [2:0] {
    REG_TOL      = 3'd0,
    REG_PERMILLE = 3'd1,
    REG_REF_W    = 3'd2,
    REG_REF_H    = 3'd3,
    REG_CUR_W    = 3'd4,
    REG_CUR_H    = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t ref_px;
    rgb_t cur_px;
  } pix_pair_t;

  typedef struct packed {
    logic [7:0]       thr;
    logic [ACC_W-1:0] limit_x;
    logic [DIM_W-1:0] ref_w;
    logic [DIM_W-1:0] ref_h;
    logic [DIM_W-1:0] cur_w;
    logic [DIM_W-1:0] cur_h;
    logic             mismatch;
    logic             busy;
  } cfg_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [REG_DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: rtl/fdmd_cfg.sv
// Register file of the motion detector with its APB-style write/read port.
// Also derives the tolerance threshold and the high-quantity product; uses fdmd_pkg.
module fdmd_cfg
  import fdmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [PCT_W-1:0]     tol_q;
  logic [PERM_W-1:0]    perm_q;
  logic [REG_DIM_W-1:0] ref_w_q, ref_h_q, cur_w_q, cur_h_q;
  logic [1:0]           settle_q;
  logic [2*DIM_W-1:0]   wh_q;
  logic [ACC_W-1:0]     x_q;
  logic [14:0]          pct_q;
  logic [7:0]           thr_q;
  logic                 wr;
  logic [DIM_W-1:0]     ref_w_eff, ref_h_eff, cur_w_eff, cur_h_eff;
  logic [27:0]          thr_prod;
  logic [8:0]           thr_raw;
  logic [2*DIM_W+PERM_W-1:0] x_full;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q    <= PCT_W'(10);
      perm_q   <= PERM_W'(10);
      ref_w_q  <= REG_DIM_W'(640);
      ref_h_q  <= REG_DIM_W'(480);
      cur_w_q  <= REG_DIM_W'(640);
      cur_h_q  <= REG_DIM_W'(480);
      settle_q <= 2'd3;
    end else begin
      if (wr) begin
        unique case (reg_idx_e'(paddr[4:2]))
          REG_TOL:      tol_q   <= pwdata[PCT_W-1:0];
          REG_PERMILLE: perm_q  <= pwdata[PERM_W-1:0];
          REG_REF_W:    ref_w_q <= pwdata[REG_DIM_W-1:0];
          REG_REF_H:    ref_h_q <= pwdata[REG_DIM_W-1:0];
          REG_CUR_W:    cur_w_q <= pwdata[REG_DIM_W-1:0];
          REG_CUR_H:    cur_h_q <= pwdata[REG_DIM_W-1:0];
          default: ;
        endcase
      end
      if (wr) begin
        settle_q <= 2'd3;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_TOL:      prdata = 32'(tol_q);
      REG_PERMILLE: prdata = 32'(perm_q);
      REG_REF_W:    prdata = 32'(ref_w_q);
      REG_REF_H:    prdata = 32'(ref_h_q);
      REG_CUR_W:    prdata = 32'(cur_w_q);
      REG_CUR_H:    prdata = 32'(cur_h_q);
      default:      prdata = '0;
    endcase
  end

  assign ref_w_eff = eff_dim(ref_w_q);
  assign ref_h_eff = eff_dim(ref_h_q);
  assign cur_w_eff = eff_dim(cur_w_q);
  assign cur_h_eff = eff_dim(cur_h_q);

  assign thr_prod = 28'(pct_q) * 28'(PCT_RECIP);
  assign thr_raw  = thr_prod[PCT_RECIP_SHIFT +: 9];
  assign x_full   = (2*DIM_W+PERM_W)'(wh_q) * (2*DIM_W+PERM_W)'(perm_q);

  always_ff @(posedge clk_i) begin
    pct_q <= {tol_q, 8'd0} - 15'(tol_q);
    thr_q <= thr_raw[8] ? 8'hFF : thr_raw[7:0];
    wh_q  <= (2*DIM_W)'(ref_w_eff) * (2*DIM_W)'(ref_h_eff);
    x_q   <= x_full[ACC_W-1:0];
  end

  always_comb begin
    cfg_o.thr      = thr_q;
    cfg_o.limit_x  = x_q;
    cfg_o.ref_w    = ref_w_eff;
    cfg_o.ref_h    = ref_h_eff;
    cfg_o.cur_w    = cur_w_eff;
    cfg_o.cur_h    = cur_h_eff;
    cfg_o.mismatch = (ref_w_q != cur_w_q) || (ref_h_q != cur_h_q);
    cfg_o.busy     = settle_q != 2'd0;
  end

endmodule

FILE: rtl/fdmd_core.sv
// Pixel datapath of the motion detector: input register, per-pixel compare,
// frame counters, bounding box and result register. Uses fdmd_pkg.
module fdmd_core
  import fdmd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pix_pair_t          pix_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rgb_t               out_px_o,
  output logic               pixel_changed_o,
  output logic [4:0]         status_flags_o,
  output logic [CNT_W-1:0]   changed_count_o,
  output logic [DIM_W-1:0]   box_min_x_o,
  output logic [COORD_W-1:0] box_max_x_o,
  output logic [DIM_W-1:0]   box_min_y_o,
  output logic [COORD_W-1:0] box_max_y_o,
  output logic               frame_done_o
);

  logic               in_vld_q, out_vld_q, advance, accept;
  pix_pair_t          px_q;
  logic [COORD_W-1:0] col_q, row_q, col_d, row_d;
  logic [7:0]         thr_q, thr;
  logic [ACC_W-1:0]   x_q, x;
  logic [2:0]         flags_q, flags_b, flags_d, f;
  logic [CNT_W-1:0]   cnt_q, cnt_b, cnt_d;
  logic [ACC_W-1:0]   acc_q, accp_q, acc_b, accp_b, acc_d;
  logic [DIM_W-1:0]   minc_q, minc_b, minc_d, minr_q, minr_b, minr_d;
  logic [COORD_W-1:0] maxc_q, maxc_b, maxc_d, maxr_q, maxr_b, maxr_d;
  logic               start, changed, inc, done, high;
  logic [10:0]        g5;
  rgb_t               px_d;

  assign advance     = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = cfg_i.busy || (in_vld_q && !advance);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      col_q     <= '0;
      row_q     <= '0;
    end else begin
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
        col_q     <= col_d;
        row_q     <= row_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_comb begin
    start   = (col_q == '0) && (row_q == '0);
    thr     = start ? cfg_i.thr : thr_q;
    x       = start ? cfg_i.limit_x : x_q;
    flags_b = start ? 3'd0 : flags_q;
    cnt_b   = start ? '0 : cnt_q;
    acc_b   = start ? '0 : acc_q;
    accp_b  = start ? PERMILLE_DEN : accp_q;
    minc_b  = start ? cfg_i.ref_w : minc_q;
    minr_b  = start ? cfg_i.ref_h : minr_q;
    maxc_b  = start ? '0 : maxc_q;
    maxr_b  = start ? '0 : maxr_q;

    f[0] = absdiff(px_q.ref_px.blue, px_q.cur_px.blue) > thr;
    f[1] = absdiff(px_q.ref_px.green, px_q.cur_px.green) > thr;
    f[2] = absdiff(px_q.ref_px.red, px_q.cur_px.red) > thr;
    if (cfg_i.mismatch) begin
      f = 3'd0;
    end
    changed = f != 3'd0;
    flags_d = flags_b | f;
    inc     = changed && (cnt_b != CNT_MAX);
    cnt_d   = inc ? cnt_b + CNT_W'(1) : cnt_b;
    acc_d   = inc ? accp_b : acc_b;

    minc_d = (changed && (DIM_W'(col_q) < minc_b)) ? DIM_W'(col_q) : minc_b;
    maxc_d = (changed && (col_q > maxc_b)) ? col_q : maxc_b;
    minr_d = (changed && (DIM_W'(row_q) < minr_b)) ? DIM_W'(row_q) : minr_b;
    maxr_d = (changed && (row_q > maxr_b)) ? row_q : maxr_b;

    done  = 1'b0;
    col_d = col_q + COORD_W'(1);
    row_d = row_q;
    if (DIM_W'(col_q) + DIM_W'(1) >= cfg_i.cur_w) begin
      col_d = '0;
      if (DIM_W'(row_q) + DIM_W'(1) >= cfg_i.cur_h) begin
        row_d = '0;
        done  = 1'b1;
      end else begin
        row_d = row_q + COORD_W'(1);
      end
    end
    high = done && (acc_d > x);

    g5 = {1'b0, px_q.cur_px.blue, 2'b00} + 11'(px_q.cur_px.blue);
    px_d = px_q.cur_px;
    if (changed) begin
      px_d.blue  = {1'b0, px_q.cur_px.blue[7:1]};
      px_d.green = (g5[10:1] > 10'd255) ? 8'hFF : g5[8:1];
      px_d.red   = {1'b0, px_q.cur_px.red[7:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= pix_i;
    end
    if (advance) begin
      thr_q   <= thr;
      x_q     <= x;
      flags_q <= flags_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      accp_q  <= acc_d + PERMILLE_DEN;
      minc_q  <= minc_d;
      maxc_q  <= maxc_d;
      minr_q  <= minr_d;
      maxr_q  <= maxr_d;

      out_px_o        <= px_d;
      pixel_changed_o <= changed;
      status_flags_o  <= {high, cfg_i.mismatch, flags_d};
      changed_count_o <= cnt_d;
      box_min_x_o     <= minc_d;
      box_max_x_o     <= maxc_d;
      box_min_y_o     <= minr_d;
      box_max_y_o     <= maxr_d;
      frame_done_o    <= done;
    end
  end

endmodule

FILE: rtl/frame_difference_motion_detect.sv
// Top level of the frame-difference motion detector with bounding box.
// Instantiates fdmd_cfg and fdmd_core; uses fdmd_pkg.
//
//   Channel   Handshake               Content
//   input     in_valid_i / in_stall_o  reference and current RGB pixel pair
//   output    out_valid_o / out_stall_i  recolored pixel, flags, count, box
//   config    psel/penable/pwrite      six registers at byte address 4*i
//
// One pixel pair per cycle while neither the output stalls nor the registers settle.
// The input register and the result register are the only pipeline stages.
// After reset and after every register write the input stalls
// while the threshold and the high-quantity product settle.
// A stalled output holds its result and one more transaction may be taken.
module frame_difference_motion_detect
  import fdmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  ref_blue_i,
  input  logic [7:0]  ref_green_i,
  input  logic [7:0]  ref_red_i,
  input  logic [7:0]  cur_blue_i,
  input  logic [7:0]  cur_green_i,
  input  logic [7:0]  cur_red_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_red_o,
  output logic        pixel_changed_o,
  output logic [4:0]  status_flags_o,
  output logic [22:0] changed_count_o,
  output logic [11:0] box_min_x_o,
  output logic [10:0] box_max_x_o,
  output logic [11:0] box_min_y_o,
  output logic [10:0] box_max_y_o,
  output logic        frame_done_o
);

  cfg_t               cfg;
  pix_pair_t          pix;
  rgb_t               out_px;
  logic [CNT_W-1:0]   cnt;
  logic [DIM_W-1:0]   min_x, min_y;
  logic [COORD_W-1:0] max_x, max_y;

  fdmd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_comb begin
    pix.ref_px.blue  = ref_blue_i;
    pix.ref_px.green = ref_green_i;
    pix.ref_px.red   = ref_red_i;
    pix.cur_px.blue  = cur_blue_i;
    pix.cur_px.green = cur_green_i;
    pix.cur_px.red   = cur_red_i;
  end

  fdmd_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pix_i           (pix),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_px_o        (out_px),
    .pixel_changed_o (pixel_changed_o),
    .status_flags_o  (status_flags_o),
    .changed_count_o (cnt),
    .box_min_x_o     (min_x),
    .box_max_x_o     (max_x),
    .box_min_y_o     (min_y),
    .box_max_y_o     (max_y),
    .frame_done_o    (frame_done_o)
  );

  assign out_blue_o      = out_px.blue;
  assign out_green_o     = out_px.green;
  assign out_red_o       = out_px.red;
  assign changed_count_o = 23'(cnt);
  assign box_min_x_o     = 12'(min_x);
  assign box_max_x_o     = 11'(max_x);
  assign box_min_y_o     = 12'(min_y);
  assign box_max_y_o     = 11'(max_y);

endmodule

FILE: rtl/fdmd_checker.sv
// Port-level assertions for the motion detector, bound to its top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fdmd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_green_o,
  input logic        pixel_changed_o,
  input logic [4:0]  status_flags_o,
  input logic [22:0] changed_count_o,
  input logic [11:0] box_min_x_o,
  input logic [10:0] box_max_x_o,
  input logic        frame_done_o
);

  `ASSERT_STD(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_green_o) && $stable(changed_count_o)), "stalled output transaction changed")
  `ASSERT_STD(a_changed_flags, (out_valid_o && pixel_changed_o) |-> (!status_flags_o[3] && (status_flags_o[2:0] != 3'd0)), "changed pixel without channel flag or with size mismatch")
  `ASSERT_STD(a_high_at_end, (out_valid_o && status_flags_o[4]) |-> frame_done_o, "high-quantity flag before frame end")
  `ASSERT_STD(a_box_valid, (out_valid_o && pixel_changed_o) |-> ((changed_count_o != 23'd0) && (box_min_x_o <= {1'b0, box_max_x_o})), "changed pixel with empty count or box")

endmodule

bind frame_difference_motion_detect fdmd_checker u_fdmd_checker (.*);
